[rtl/frame_pack_unpack_crc8_unit_macros.svh]
// ----------------------------------------------------------------------------
// frame_pack_unpack_crc8_unit_macros
// assertion macros used by the checker file fpcrc_checker.sv
// ----------------------------------------------------------------------------
`ifndef FRAME_PACK_UNPACK_CRC8_UNIT_MACROS_SVH
`define FRAME_PACK_UNPACK_CRC8_UNIT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define FPCRC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpcrc assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define FPCRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpcrc assertion failed");

`endif

[rtl/fpcrc_pkg.sv]
// ----------------------------------------------------------------------------
// fpcrc_pkg
// types, constants and crc helpers for the frame pack / unpack unit
// ----------------------------------------------------------------------------
`default_nettype none

package fpcrc_pkg;

  localparam int unsigned FRAME_W = 50;
  localparam int unsigned CRC_W   = 8;
  localparam int unsigned DATA_W  = 42;  // frame bits covered by the crc
  localparam int unsigned PAD_W   = 6;   // zero bits appended before the crc

  localparam logic [CRC_W-1:0] CRC_POLY   = 8'h2F;
  localparam logic [CRC_W-1:0] CRC_INIT   = 8'hFF;
  localparam logic [CRC_W-1:0] CRC_XOROUT = 8'hFF;

  localparam logic MARKER        = 1'b1;
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic {
    CMD_PACK   = 1'b0,
    CMD_UNPACK = 1'b1
  } cmd_t;

  typedef logic [DATA_W-1:0]            crc_data_t;
  typedef logic [DATA_W-1:0][CRC_W-1:0] crc_cols_t;

  typedef struct packed {
    logic               command;
    logic [1:0]         frame_type;
    logic [2:0]         sequence_req;
    logic [2:0]         acknowledge;
    logic [2:0]         flag_bits;
    logic [5:0]         code_0;
    logic [5:0]         code_1;
    logic [5:0]         code_2;
    logic [5:0]         code_3;
    logic [5:0]         code_4;
    logic [FRAME_W-1:0] raw_in;
  } in_beat_t;

  typedef struct packed {
    logic [FRAME_W-1:0] raw_out;
    logic               status;
    logic [1:0]         type_out;
    logic [2:0]         seq_out;
    logic [2:0]         ack_out;
    logic [2:0]         flags_out;
    logic [5:0]         char_0;
    logic [5:0]         char_1;
    logic [5:0]         char_2;
    logic [5:0]         char_3;
    logic [5:0]         char_4;
  } out_beat_t;

  // bit-serial crc, msb first; elaboration only: builds CRC_BASE and the columns
  function automatic logic [CRC_W-1:0] crc_serial(input crc_data_t d);
    logic [DATA_W+PAD_W-1:0] v;
    logic [CRC_W-1:0]        c;
    logic                    fb;
    v = {d, {PAD_W{1'b0}}};
    c = CRC_INIT;
    for (int i = DATA_W + PAD_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ v[i];
      c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c ^ CRC_XOROUT;
  endfunction

  // crc of the all-zero data word, init and xorout folded in
  localparam logic [CRC_W-1:0] CRC_BASE = crc_serial('0);

  // contribution of each single data bit
  function automatic crc_cols_t crc_make_cols();
    crc_cols_t cols;
    for (int j = 0; j < DATA_W; j++) begin
      cols[j] = crc_serial(crc_data_t'(1) << j) ^ CRC_BASE;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_make_cols();

  // crc as a flat xor tree over independent data bits
  function automatic logic [CRC_W-1:0] crc_fast(input crc_data_t d);
    logic [CRC_W-1:0] c;
    c = CRC_BASE;
    for (int j = 0; j < DATA_W; j++) begin
      if (d[j]) begin
        c = c ^ CRC_COLS[j];
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/frame_pack_unpack_crc8_unit.sv]
// ----------------------------------------------------------------------------
// frame_pack_unpack_crc8_unit
// packs or unpacks a 50-bit radio frame protected by crc-8/autosar
// ----------------------------------------------------------------------------
// usage
//   in channel : one beat per frame request (in_valid / in_stall / in_data);
//                command selects pack (build frame, force marker, append crc)
//                or unpack (check marker and crc, decode fields)
//   out channel: one result beat per request (out_valid / out_stall / out_data)
//   path       : an accepted beat goes through the input register, then the
//                result register, and shows on out_data from there
//   throughput : one beat per cycle without out_stall; the crc is a flat
//                42-input xor tree between the input and result registers
//   reset      : rst_n low clears both valid flags; nothing else to clear
//   stall      : out_stall holds the result register; the input register
//                keeps taking beats until it is also full, then in_stall
//                rises in the same cycle
//   rejected   : unpack with no marker or a crc mismatch gives status 1
//                and all decoded fields zero
// ----------------------------------------------------------------------------
`default_nettype none

module frame_pack_unpack_crc8_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire fpcrc_pkg::in_beat_t in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output fpcrc_pkg::out_beat_t out_data
);

  // pipeline registers
  logic                 s1_valid_r, s1_valid_nxt;
  fpcrc_pkg::in_beat_t  s1_data_r;
  logic                 out_valid_r, out_valid_nxt;
  fpcrc_pkg::out_beat_t out_data_r;

  // handshake
  logic out_load;
  logic s1_load;

  // datapath
  fpcrc_pkg::crc_data_t          crc_data;
  logic [fpcrc_pkg::CRC_W-1:0]   crc_value;
  logic                          is_unpack;
  logic                          frame_ok;
  fpcrc_pkg::out_beat_t          result;

  // result register frees up when empty or being taken this cycle
  assign out_load = !out_valid_r || !out_stall;
  // input register moves on when empty or draining into the result register
  assign s1_load  = !s1_valid_r || out_load;
  assign in_stall = !s1_load;

  assign s1_valid_nxt  = s1_load  ? in_valid   : s1_valid_r;
  assign out_valid_nxt = out_load ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_data_r <= in_data;
    end
    if (out_load && s1_valid_r) begin
      out_data_r <= result;
    end
  end

  assign is_unpack = (s1_data_r.command == fpcrc_pkg::CMD_UNPACK);

  // covered bits: the received header and codes, or the freshly packed ones
  assign crc_data = is_unpack ?
    s1_data_r.raw_in[fpcrc_pkg::FRAME_W-1:fpcrc_pkg::CRC_W] :
    {fpcrc_pkg::MARKER, s1_data_r.frame_type, s1_data_r.sequence_req,
     s1_data_r.acknowledge, s1_data_r.flag_bits, s1_data_r.code_0,
     s1_data_r.code_1, s1_data_r.code_2, s1_data_r.code_3, s1_data_r.code_4};

  assign crc_value = fpcrc_pkg::crc_fast(crc_data);

  // marker present and stored crc matches
  assign frame_ok = (s1_data_r.raw_in[fpcrc_pkg::FRAME_W-1] == fpcrc_pkg::MARKER) &&
                    (s1_data_r.raw_in[fpcrc_pkg::CRC_W-1:0] == crc_value);

  always_comb begin
    result = '0;
    if (!is_unpack) begin
      result.raw_out = {crc_data, crc_value};
      result.status  = fpcrc_pkg::STATUS_OK;
    end else if (!frame_ok) begin
      result.status  = fpcrc_pkg::STATUS_REJECT;
    end else begin
      result.status    = fpcrc_pkg::STATUS_OK;
      result.type_out  = s1_data_r.raw_in[48:47];
      result.seq_out   = s1_data_r.raw_in[46:44];
      result.ack_out   = s1_data_r.raw_in[43:41];
      result.flags_out = s1_data_r.raw_in[40:38];
      result.char_0    = s1_data_r.raw_in[37:32];
      result.char_1    = s1_data_r.raw_in[31:26];
      result.char_2    = s1_data_r.raw_in[25:20];
      result.char_3    = s1_data_r.raw_in[19:14];
      result.char_4    = s1_data_r.raw_in[13:8];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/fpcrc_checker.sv]
// ----------------------------------------------------------------------------
// fpcrc_checker
// port-level checks for the frame pack / unpack unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_pack_unpack_crc8_unit_macros.svh"

module fpcrc_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input wire fpcrc_pkg::in_beat_t  in_data,
  input wire                  out_valid,
  input wire                  out_stall,
  input wire fpcrc_pkg::out_beat_t out_data
);

  logic decoded_zero;
  logic pack_shape_ok;
  logic reject_shape_ok;

  // every decoded field of the result beat is zero
  assign decoded_zero = (out_data.type_out == '0) && (out_data.seq_out == '0) &&
                        (out_data.ack_out == '0) && (out_data.flags_out == '0) &&
                        (out_data.char_0 == '0) && (out_data.char_1 == '0) &&
                        (out_data.char_2 == '0) && (out_data.char_3 == '0) &&
                        (out_data.char_4 == '0);

  assign pack_shape_ok = out_data.raw_out[fpcrc_pkg::FRAME_W-1] &&
                         (out_data.status == fpcrc_pkg::STATUS_OK) && decoded_zero;

  assign reject_shape_ok = (out_data.raw_out == '0) && decoded_zero;

  // held request beat stays put
  `FPCRC_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

  // held result beat stays put
  `FPCRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // with the result side empty the input side never stalls
  `FPCRC_ASSERT_SAME(a_no_false_stall, !out_valid, !in_stall)

  // a frame on raw_out always carries the marker and no decoded fields
  `FPCRC_ASSERT_SAME(a_pack_shape, out_valid && (out_data.raw_out != '0), pack_shape_ok)

  // a rejected frame shows only zeros besides status
  `FPCRC_ASSERT_SAME(a_reject_zero, out_valid && out_data.status, reject_shape_ok)

endmodule

bind frame_pack_unpack_crc8_unit fpcrc_checker u_fpcrc_checker (.*);

`default_nettype wire
